FILE: hw/rtl/ffba_pkg.sv
// Package for the first-fit block allocator: word types, sequencer states
// and fixed constants. No dependencies.
package ffba_pkg;

	localparam int TAG_W   = 8;
	localparam int COUNT_W = 11;
	localparam int LOC_W   = 10;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [TAG_W-1:0]   FREE_TAG        = '0;
	localparam logic [COUNT_W-1:0] CELLS_IN_USE_RST = 11'd1000;

	// Request codes
	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	// Register index (byte address divided by four)
	localparam logic [PADDR_W-3:0] REG_CELLS_IN_USE = '0;

	typedef struct packed {
		logic               func;
		logic [TAG_W-1:0]   owner_tag;
		logic [COUNT_W-1:0] block_count;
	} in_word_t;

	typedef struct packed {
		logic             granted;
		logic [LOC_W-1:0] start_location;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FILL,
		ST_FREE,
		ST_DONE
	} ffba_state_t;

endpackage

FILE: hw/rtl/ffba_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/ffba_seq.sv
// Sequencer of the first-fit block allocator: clearing pass, first-fit scan,
// run fill and release sweep over the owner RAM. Depends on ffba_pkg.
module ffba_seq import ffba_pkg::*; #(
	parameter int CELLS = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [COUNT_W-1:0]       cells_in_use,
	input  logic                     req_valid,
	input  in_word_t                 req,
	output logic                     req_take,
	output logic                     res_valid,
	input  logic                     res_ready,
	output out_word_t                res,
	output logic                     mem_we,
	output logic [$clog2(CELLS)-1:0] mem_waddr,
	output logic [TAG_W-1:0]         mem_wdata,
	output logic [$clog2(CELLS)-1:0] mem_raddr,
	input  logic [TAG_W-1:0]         mem_rdata
);

	localparam int AW = $clog2(CELLS);
	localparam int NW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;

	ffba_state_t        state_q, state_d;
	logic [NW-1:0]      n_q, rd_addr_q, run_q;
	logic [AW-1:0]      rd_idx_s1, first_q, fill_q, clr_q;
	logic               rd_vld_s1;
	logic [TAG_W-1:0]   tag_q;
	logic [COUNT_W-1:0] cnt_q, left_q;
	out_word_t          res_q;

	logic          accept, issue, hit, cell_free;
	logic [NW-1:0] cells_ext, n_act;
	logic [AW-1:0] first_now;

	assign cells_ext = NW'(cells_in_use);
	assign n_act     = (cells_ext > NW'(CELLS)) ? NW'(CELLS) : cells_ext;
	assign cell_free = (mem_rdata == FREE_TAG);
	assign first_now = (run_q == '0) ? rd_idx_s1 : first_q;
	assign hit       = (state_q == ST_SCAN) && rd_vld_s1 && cell_free &&
	                   ((run_q + NW'(1)) == NW'(cnt_q));
	assign issue     = ((state_q == ST_SCAN) || (state_q == ST_FREE)) &&
	                   (rd_addr_q < n_q) && !hit;
	assign accept    = req_take && req_valid;
	assign mem_raddr = rd_addr_q[AW-1:0];
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_take  = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = FREE_TAG;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == AW'(CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_take = 1'b1;
				if (req_valid) begin
					priority if (req.func == FUNC_RELEASE) begin
						state_d = ST_FREE;
					end else if (req.owner_tag == FREE_TAG || req.block_count == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_d = ST_FILL;
				end else if (!issue && !rd_vld_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = fill_q;
				mem_wdata = tag_q;
				if (left_q == COUNT_W'(1)) begin
					state_d = ST_DONE;
				end
			end
			ST_FREE: begin
				if (rd_vld_s1 && mem_rdata == tag_q) begin
					mem_we    = 1'b1;
					mem_waddr = rd_idx_s1;
				end
				if (!issue && !rd_vld_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			clr_q     <= '0;
		end else begin
			rd_vld_s1 <= issue;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr_q[AW-1:0];
		if (accept) begin
			rd_addr_q <= '0;
			run_q     <= '0;
			n_q       <= n_act;
			tag_q     <= req.owner_tag;
			cnt_q     <= req.block_count;
			res_q     <= '{granted: req.func, start_location: '0};
		end else begin
			if (issue) begin
				rd_addr_q <= rd_addr_q + NW'(1);
			end
			if (state_q == ST_SCAN && rd_vld_s1) begin
				if (cell_free) begin
					run_q   <= run_q + NW'(1);
					first_q <= first_now;
				end else begin
					run_q <= '0;
				end
			end
			if (hit) begin
				fill_q <= first_now;
				left_q <= cnt_q;
				res_q  <= '{granted: 1'b1, start_location: LOC_W'(NW'(first_now))};
			end else if (state_q == ST_FILL) begin
				fill_q <= fill_q + AW'(1);
				left_q <= left_q - COUNT_W'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/first_fit_block_allocator.sv
// First-fit block allocator: an owner tag per cell in one RAM, swept one cell a cycle.
// Allocate: scan the active cells for the first free run of block_count and fill it,
// then give the result word. Release: free the cells holding the tag. One request at a time.
// After reset a clearing pass writes every cell free before a word is taken.
// Reset also returns cells_in_use to 1000. Depends on ffba_pkg, ffba_seq and ffba_ram.
module first_fit_block_allocator import ffba_pkg::*; #(
	parameter int CELLS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  in_word_t           in_word,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output out_word_t          out_word,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int AW = $clog2(CELLS);

	logic [COUNT_W-1:0] cells_in_use_q;
	logic               out_valid_q;
	out_word_t          out_word_q;

	logic               req_take, res_valid, res_ready;
	out_word_t          res;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic [TAG_W-1:0]   mem_wdata, mem_rdata;
	logic               cfg_wr;

	// Register file: a single register, cells_in_use, at byte address zero.
	// The access phase completes the write since pready never drops.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_in_use_q <= CELLS_IN_USE_RST;
		end else if (cfg_wr && paddr[PADDR_W-1:2] == REG_CELLS_IN_USE) begin
			cells_in_use_q <= pwdata[COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[PADDR_W-1:2] == REG_CELLS_IN_USE) begin
			prdata = PDATA_W'(cells_in_use_q);
		end
	end

	// Requests are taken only while the sequencer sits idle; a finished word
	// waiting in the output register does not hold the next request back.
	assign in_stall = !req_take;

	// Output register: load a finished word when the slot is empty or is
	// being emptied this cycle, otherwise hold it.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_word_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// Scan, fill, release and clearing sequencer
	ffba_seq #(
		.CELLS(CELLS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cells_in_use(cells_in_use_q),
		.req_valid   (in_valid),
		.req         (in_word),
		.req_take    (req_take),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	// Owner tag store, one entry per cell
	ffba_ram #(
		.WIDTH(TAG_W),
		.DEPTH(CELLS)
	) u_owner_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule
